FILE: rtl/obstacle_avoid_velocity_supervisor_defines.svh
//------------------------------------------------------------------------------
// Obstacle avoidance velocity supervisor: assertion macros
// Shared concurrent assertion macros for the supervisor's checker.
//------------------------------------------------------------------------------
`ifndef OBSTACLE_AVOID_VELOCITY_SUPERVISOR_DEFINES_SVH
`define OBSTACLE_AVOID_VELOCITY_SUPERVISOR_DEFINES_SVH

// Consequent checked on the same clock edge as the antecedent.
`define OAVS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked on the clock edge after the antecedent.
`define OAVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/oavs_pkg.sv
//------------------------------------------------------------------------------
// Obstacle avoidance velocity supervisor: package
// Constants, mode codes, interface structures and arithmetic helpers.
//------------------------------------------------------------------------------
package oavs_pkg;

    localparam int RANGE_MAX_MM = 2000;
    localparam int STALE_MS     = 200;
    localparam int SPEED_LIMIT  = 300;
    localparam int PUSH_MAX     = 200;
    localparam int SLEW_CAP     = 16384;

    localparam int NUM_SENSORS  = 4;
    localparam int SENS_FRONT   = 0;
    localparam int SENS_LEFT    = 1;
    localparam int SENS_RIGHT   = 2;
    localparam int SENS_BACK    = 3;

    localparam int TIME_W       = 32;
    localparam int RAW_W        = 16;
    localparam int MM_W         = 11;
    localparam int FILT_W       = 15;
    localparam int VEL_W        = 13;
    localparam int CMD_W        = 10;
    localparam int HOLD_W       = 16;
    localparam int STEP_W       = 15;
    localparam int PUSH_W       = 8;
    localparam int MODE_W       = 3;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [FILT_W-1:0] FILT_RESET = FILT_W'(RANGE_MAX_MM * 16);

    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRONT_ENTER = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRONT_CLEAR = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIDE_ENTER  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIDE_CLEAR  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BACK_ENTER  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_BACK_CLEAR  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLEAR_HOLD  = 3'd7;

    localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SIDE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FRONT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REAR     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEARING = 3'd4;

    typedef enum logic [4:0] {
        ST_NORMAL   = 5'b00001,
        ST_SIDE     = 5'b00010,
        ST_FRONT    = 5'b00100,
        ST_REAR     = 5'b01000,
        ST_CLEARING = 5'b10000
    } oavs_state_t;

    typedef struct packed {
        logic              enable;
        logic [MM_W-1:0]   front_enter;
        logic [MM_W-1:0]   front_clear;
        logic [MM_W-1:0]   side_enter;
        logic [MM_W-1:0]   side_clear;
        logic [MM_W-1:0]   back_enter;
        logic [MM_W-1:0]   back_clear;
        logic [HOLD_W-1:0] clear_hold;
    } oavs_cfg_t;

    typedef struct packed {
        oavs_state_t              state;
        logic                     side_right;
        logic                     load_prev;
        logic [FILT_W-1:0]        front;
        logic [FILT_W-1:0]        back;
        logic [FILT_W-1:0]        side;
        logic signed [VEL_W-1:0]  vx_in;
        logic signed [VEL_W-1:0]  vy_in;
        logic [STEP_W-1:0]        step;
    } oavs_cmd_req_t;

    function automatic logic [MODE_W-1:0] mode_code(input oavs_state_t st);
        logic [MODE_W-1:0] code;
        case (st)
            ST_SIDE:     code = MODE_SIDE;
            ST_FRONT:    code = MODE_FRONT;
            ST_REAR:     code = MODE_REAR;
            ST_CLEARING: code = MODE_CLEARING;
            default:     code = MODE_NORMAL;
        endcase
        return code;
    endfunction

    // Push in mm/s from an error in 1/16 mm: whole millimetres, capped.
    function automatic logic [PUSH_W-1:0] push_mag(input logic signed [FILT_W:0] err);
        logic [FILT_W-5:0] whole;
        logic [PUSH_W-1:0] res;
        whole = err[FILT_W-1:4];
        if (err <= 0) begin
            res = '0;
        end else if (whole > PUSH_MAX) begin
            res = PUSH_W'(PUSH_MAX);
        end else begin
            res = whole[PUSH_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [CMD_W-1:0] clamp_cmd(input logic signed [VEL_W:0] v);
        logic signed [CMD_W-1:0] res;
        if (v > SPEED_LIMIT) begin
            res = CMD_W'(SPEED_LIMIT);
        end else if (v < -SPEED_LIMIT) begin
            res = CMD_W'(-SPEED_LIMIT);
        end else begin
            res = v[CMD_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/obstacle_avoid_velocity_supervisor.sv
// A tick's accepted beat is registered in the lane stage, then in the mode stage
// and then in the command stage, whose register offers the result.
// Throughput: one tick per cycle while the result channel does not stall; each
// of the three stages holds its item until the next stage is free, so the output
// register stalls only what is behind it. The sensor lanes (while enabled), the
// mode register and the lateral command register each update once per tick.
// Reset (aresetn low, synchronous) empties the pipeline and restores control state.
//------------------------------------------------------------------------------
// Obstacle avoidance velocity supervisor
// Four sensor lanes filter the ranges side by side, a merge stage runs the
// avoidance mode machine and a command stage forms the clamped velocities.
//------------------------------------------------------------------------------
module obstacle_avoid_velocity_supervisor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [oavs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [oavs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0], front_raw[47:32], left_raw[63:48], right_raw[79:64],
    // back_raw[95:80], deck_ready[96], vx_in[109:97], vy_in[122:110]
    input  logic [127:0]                        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // vx_out[9:0], vy_out[19:10], mode[22:20]
    output logic [23:0]                         m_tdata,
    // take_over[0]
    output logic                                m_tuser
);

    localparam int NS = oavs_pkg::NUM_SENSORS;

    oavs_pkg::oavs_cfg_t                    cfg_reg;
    logic                                   v1_reg;
    logic                                   v2_reg;
    logic                                   v3_reg;
    logic [oavs_pkg::TIME_W-1:0]            last_tick_reg;
    logic [oavs_pkg::TIME_W-1:0]            now1_reg;
    logic                                   deck1_reg;
    logic signed [oavs_pkg::VEL_W-1:0]      vx1_reg;
    logic signed [oavs_pkg::VEL_W-1:0]      vy1_reg;
    logic [oavs_pkg::STEP_W-1:0]            step1_reg;
    logic [oavs_pkg::STEP_W-1:0]            step_next;

    logic [oavs_pkg::TIME_W-1:0]            in_now;
    logic [NS-1:0][oavs_pkg::RAW_W-1:0]     in_raw;
    logic [oavs_pkg::TIME_W-1:0]            dt;
    logic                                   in_fire;
    logic                                   move1;
    logic                                   move2;
    logic                                   rdy2;
    logic                                   rdy3;
    logic                                   active;
    logic [NS-1:0][oavs_pkg::FILT_W-1:0]    ranges;
    logic [NS-1:0]                          fresh;
    oavs_pkg::oavs_cmd_req_t                req;
    logic                                   take_over;
    logic signed [oavs_pkg::CMD_W-1:0]      vx_out;
    logic signed [oavs_pkg::CMD_W-1:0]      vy_out;
    logic [oavs_pkg::MODE_W-1:0]            mode;

    assign in_now = s_tdata[31:0];
    assign in_raw[oavs_pkg::SENS_FRONT] = s_tdata[47:32];
    assign in_raw[oavs_pkg::SENS_LEFT]  = s_tdata[63:48];
    assign in_raw[oavs_pkg::SENS_RIGHT] = s_tdata[79:64];
    assign in_raw[oavs_pkg::SENS_BACK]  = s_tdata[95:80];

    assign rdy3     = !v3_reg || m_tready;
    assign move2    = v2_reg && rdy3;
    assign rdy2     = !v2_reg || rdy3;
    assign move1    = v1_reg && rdy2;
    assign s_tready = !v1_reg || rdy2;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        dt = in_now - last_tick_reg;
        if (dt >= oavs_pkg::TIME_W'(oavs_pkg::SLEW_CAP / 2)) begin
            step_next = oavs_pkg::STEP_W'(oavs_pkg::SLEW_CAP);
        end else begin
            step_next = {dt[oavs_pkg::STEP_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable      <= 1'b0;
            cfg_reg.front_enter <= 11'd400;
            cfg_reg.front_clear <= 11'd550;
            cfg_reg.side_enter  <= 11'd300;
            cfg_reg.side_clear  <= 11'd450;
            cfg_reg.back_enter  <= 11'd300;
            cfg_reg.back_clear  <= 11'd450;
            cfg_reg.clear_hold  <= 16'd300;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                oavs_pkg::CFG_ENABLE:      cfg_reg.enable      <= cfg_wdata[0];
                oavs_pkg::CFG_FRONT_ENTER: cfg_reg.front_enter <= cfg_wdata[10:0];
                oavs_pkg::CFG_FRONT_CLEAR: cfg_reg.front_clear <= cfg_wdata[10:0];
                oavs_pkg::CFG_SIDE_ENTER:  cfg_reg.side_enter  <= cfg_wdata[10:0];
                oavs_pkg::CFG_SIDE_CLEAR:  cfg_reg.side_clear  <= cfg_wdata[10:0];
                oavs_pkg::CFG_BACK_ENTER:  cfg_reg.back_enter  <= cfg_wdata[10:0];
                oavs_pkg::CFG_BACK_CLEAR:  cfg_reg.back_clear  <= cfg_wdata[10:0];
                oavs_pkg::CFG_CLEAR_HOLD:  cfg_reg.clear_hold  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            last_tick_reg <= '0;
        end else begin
            if (in_fire) begin
                v1_reg        <= 1'b1;
                last_tick_reg <= in_now;
            end else if (move1) begin
                v1_reg <= 1'b0;
            end
            if (move1) begin
                v2_reg <= 1'b1;
            end else if (move2) begin
                v2_reg <= 1'b0;
            end
            if (move2) begin
                v3_reg <= 1'b1;
            end else if (m_tready) begin
                v3_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            now1_reg  <= in_now;
            deck1_reg <= s_tdata[96];
            vx1_reg   <= s_tdata[109:97];
            vy1_reg   <= s_tdata[122:110];
            step1_reg <= step_next;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_lane
        oavs_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .upd     (in_fire && cfg_reg.enable),
            .now     (in_now),
            .raw     (in_raw[k]),
            .filt    (ranges[k]),
            .fresh   (fresh[k])
        );
    end

    assign active = cfg_reg.enable && deck1_reg && (|fresh);

    oavs_mode u_mode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (move1),
        .active  (active),
        .now     (now1_reg),
        .ranges  (ranges),
        .vx_in   (vx1_reg),
        .vy_in   (vy1_reg),
        .step    (step1_reg),
        .cfg     (cfg_reg),
        .req     (req)
    );

    oavs_cmd u_cmd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (move2),
        .req       (req),
        .cfg       (cfg_reg),
        .take_over (take_over),
        .vx_out    (vx_out),
        .vy_out    (vy_out),
        .mode      (mode)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {1'b0, mode, vy_out, vx_out};
    assign m_tuser  = take_over;

endmodule

FILE: rtl/oavs_lane.sv
//------------------------------------------------------------------------------
// Obstacle avoidance velocity supervisor: sensor lane
// Clamps and low-passes one range reading and tracks its freshness.
//------------------------------------------------------------------------------
module oavs_lane (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               upd,
    input  logic [oavs_pkg::TIME_W-1:0]        now,
    input  logic [oavs_pkg::RAW_W-1:0]         raw,
    output logic [oavs_pkg::FILT_W-1:0]        filt,
    output logic                               fresh
);

    logic [oavs_pkg::FILT_W-1:0] filt_reg;
    logic [oavs_pkg::FILT_W-1:0] filt_next;
    logic [oavs_pkg::TIME_W-1:0] seen_reg;
    logic                        fresh_reg;
    logic                        fresh_next;
    logic [oavs_pkg::MM_W-1:0]   raw_mm;
    logic signed [oavs_pkg::FILT_W:0] diff;
    logic signed [oavs_pkg::FILT_W:0] step;
    logic [oavs_pkg::TIME_W-1:0] age;

    always_comb begin
        raw_mm     = (raw > oavs_pkg::RANGE_MAX_MM) ? oavs_pkg::MM_W'(oavs_pkg::RANGE_MAX_MM)
                                                    : raw[oavs_pkg::MM_W-1:0];
        diff       = $signed({1'b0, raw_mm, 4'b0000}) - $signed({1'b0, filt_reg});
        step       = diff >>> 2;
        filt_next  = oavs_pkg::FILT_W'($signed({1'b0, filt_reg}) + step);
        age        = now - seen_reg;
        fresh_next = (raw != '0) || (age <= oavs_pkg::STALE_MS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg  <= oavs_pkg::FILT_RESET;
            seen_reg  <= '0;
            fresh_reg <= 1'b0;
        end else if (upd) begin
            if (raw != '0) begin
                filt_reg <= filt_next;
                seen_reg <= now;
            end
            fresh_reg <= fresh_next;
        end
    end

    assign filt  = filt_reg;
    assign fresh = fresh_reg;

endmodule

FILE: rtl/oavs_mode.sv
//------------------------------------------------------------------------------
// Obstacle avoidance velocity supervisor: mode merge
// Combines the lane ranges into the avoidance mode with hysteresis and a
// debounced release, and registers the request for the command stage.
//------------------------------------------------------------------------------
module oavs_mode (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           advance,
    input  logic                                           active,
    input  logic [oavs_pkg::TIME_W-1:0]                    now,
    input  logic [oavs_pkg::NUM_SENSORS-1:0][oavs_pkg::FILT_W-1:0] ranges,
    input  logic signed [oavs_pkg::VEL_W-1:0]              vx_in,
    input  logic signed [oavs_pkg::VEL_W-1:0]              vy_in,
    input  logic [oavs_pkg::STEP_W-1:0]                    step,
    input  oavs_pkg::oavs_cfg_t                            cfg,
    output oavs_pkg::oavs_cmd_req_t                        req
);

    oavs_pkg::oavs_state_t       state_reg;
    oavs_pkg::oavs_state_t       state_next;
    logic                        side_right_reg;
    logic                        side_right_next;
    logic                        timing_reg;
    logic                        timing_next;
    logic [oavs_pkg::TIME_W-1:0] start_reg;
    logic [oavs_pkg::TIME_W-1:0] start_next;
    oavs_pkg::oavs_cmd_req_t     req_reg;
    oavs_pkg::oavs_cmd_req_t     req_next;

    logic [oavs_pkg::FILT_W-1:0] f;
    logic [oavs_pkg::FILT_W-1:0] l;
    logic [oavs_pkg::FILT_W-1:0] r;
    logic [oavs_pkg::FILT_W-1:0] b;
    logic [oavs_pkg::FILT_W-1:0] near;
    logic [oavs_pkg::FILT_W-1:0] fe16;
    logic [oavs_pkg::FILT_W-1:0] fc16;
    logic [oavs_pkg::FILT_W-1:0] se16;
    logic [oavs_pkg::FILT_W-1:0] sc16;
    logic [oavs_pkg::FILT_W-1:0] be16;
    logic [oavs_pkg::FILT_W-1:0] bc16;
    logic                        release_ok;
    logic                        load_prev;

    always_comb begin
        f    = ranges[oavs_pkg::SENS_FRONT];
        l    = ranges[oavs_pkg::SENS_LEFT];
        r    = ranges[oavs_pkg::SENS_RIGHT];
        b    = ranges[oavs_pkg::SENS_BACK];
        fe16 = {cfg.front_enter, 4'b0000};
        fc16 = {cfg.front_clear, 4'b0000};
        se16 = {cfg.side_enter, 4'b0000};
        sc16 = {cfg.side_clear, 4'b0000};
        be16 = {cfg.back_enter, 4'b0000};
        bc16 = {cfg.back_clear, 4'b0000};

        state_next      = state_reg;
        side_right_next = side_right_reg;
        timing_next     = timing_reg;
        start_next      = start_reg;
        release_ok      = 1'b0;
        load_prev       = 1'b0;

        if (active) begin
            if (state_next == oavs_pkg::ST_NORMAL) begin
                if (f < fe16) begin
                    state_next  = oavs_pkg::ST_FRONT;
                    timing_next = 1'b0;
                end else if (b < be16) begin
                    state_next  = oavs_pkg::ST_REAR;
                    timing_next = 1'b0;
                end else if (r < se16) begin
                    state_next      = oavs_pkg::ST_SIDE;
                    side_right_next = 1'b1;
                    timing_next     = 1'b0;
                end else if (l < se16) begin
                    state_next      = oavs_pkg::ST_SIDE;
                    side_right_next = 1'b0;
                    timing_next     = 1'b0;
                end
            end
            if (state_next == oavs_pkg::ST_SIDE && f < fe16) begin
                state_next  = oavs_pkg::ST_FRONT;
                timing_next = 1'b0;
            end

            case (state_next)
                oavs_pkg::ST_FRONT: release_ok = f > fc16;
                oavs_pkg::ST_REAR:  release_ok = b > bc16;
                oavs_pkg::ST_SIDE:  release_ok = ((side_right_next ? r : l) > sc16)
                                                 && (f > fe16) && (b > be16);
                default:            release_ok = 1'b0;
            endcase

            case (state_next)
                oavs_pkg::ST_FRONT, oavs_pkg::ST_REAR, oavs_pkg::ST_SIDE: begin
                    if (release_ok) begin
                        if (!timing_next) begin
                            timing_next = 1'b1;
                            start_next  = now;
                        end
                        if ((now - start_next) >= oavs_pkg::TIME_W'(cfg.clear_hold)) begin
                            state_next  = oavs_pkg::ST_CLEARING;
                            timing_next = 1'b0;
                        end
                    end else begin
                        timing_next = 1'b0;
                    end
                end
                oavs_pkg::ST_CLEARING: begin
                    state_next = oavs_pkg::ST_NORMAL;
                    load_prev  = 1'b1;
                end
                default: begin
                end
            endcase
        end else begin
            state_next = oavs_pkg::ST_NORMAL;
        end

        near                = side_right_next ? r : l;
        req_next.state      = state_next;
        req_next.side_right = side_right_next;
        req_next.load_prev  = load_prev;
        req_next.front      = f;
        req_next.back       = b;
        req_next.side       = near;
        req_next.vx_in      = vx_in;
        req_next.vy_in      = vy_in;
        req_next.step       = step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= oavs_pkg::ST_NORMAL;
            side_right_reg <= 1'b0;
            timing_reg     <= 1'b0;
            start_reg      <= '0;
        end else if (advance) begin
            state_reg      <= state_next;
            side_right_reg <= side_right_next;
            timing_reg     <= timing_next;
            start_reg      <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            req_reg <= req_next;
        end
    end

    assign req = req_reg;

endmodule

FILE: rtl/oavs_cmd.sv
//------------------------------------------------------------------------------
// Obstacle avoidance velocity supervisor: command stage
// Forms the override velocities, slews the side push and clamps the result.
//------------------------------------------------------------------------------
module oavs_cmd (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  advance,
    input  oavs_pkg::oavs_cmd_req_t               req,
    input  oavs_pkg::oavs_cfg_t                   cfg,
    output logic                                  take_over,
    output logic signed [oavs_pkg::CMD_W-1:0]     vx_out,
    output logic signed [oavs_pkg::CMD_W-1:0]     vy_out,
    output logic [oavs_pkg::MODE_W-1:0]           mode
);

    localparam int VW = oavs_pkg::VEL_W;

    logic signed [VW-1:0]                 prev_reg;
    logic signed [VW-1:0]                 prev_next;
    logic                                 take_reg;
    logic signed [oavs_pkg::CMD_W-1:0]    vx_reg;
    logic signed [oavs_pkg::CMD_W-1:0]    vy_reg;
    logic [oavs_pkg::MODE_W-1:0]          mode_reg;

    logic signed [oavs_pkg::FILT_W:0]     err_f;
    logic signed [oavs_pkg::FILT_W:0]     err_b;
    logic signed [oavs_pkg::FILT_W:0]     err_s;
    logic [oavs_pkg::PUSH_W-1:0]          push_f;
    logic [oavs_pkg::PUSH_W-1:0]          push_b;
    logic [oavs_pkg::PUSH_W-1:0]          push_s;
    logic signed [VW:0]                   vx_ext;
    logic signed [VW:0]                   vy_ext;
    logic signed [VW:0]                   vx_sel;
    logic signed [VW:0]                   vy_sel;
    logic signed [VW:0]                   push_ext;
    logic signed [VW-1:0]                 target;
    logic signed [VW:0]                   gap;
    logic signed [VW+2:0]                 gap_w;
    logic signed [VW+2:0]                 step_w;
    logic signed [VW+2:0]                 prev_w;
    logic signed [VW-1:0]                 slewed;
    logic                                 take;

    always_comb begin
        err_f  = $signed({1'b0, cfg.front_clear, 4'b0000}) - $signed({1'b0, req.front});
        err_b  = $signed({1'b0, cfg.back_clear, 4'b0000}) - $signed({1'b0, req.back});
        err_s  = $signed({1'b0, cfg.side_clear, 4'b0000}) - $signed({1'b0, req.side});
        push_f = oavs_pkg::push_mag(err_f);
        push_b = oavs_pkg::push_mag(err_b);
        push_s = oavs_pkg::push_mag(err_s);
        vx_ext = {req.vx_in[VW-1], req.vx_in};
        vy_ext = {req.vy_in[VW-1], req.vy_in};

        if (err_s > 0) begin
            target = req.side_right ? $signed(VW'(push_s)) : -$signed(VW'(push_s));
        end else begin
            target = req.vy_in;
        end
        gap    = $signed({target[VW-1], target}) - $signed({prev_reg[VW-1], prev_reg});
        gap_w  = {{2{gap[VW]}}, gap};
        step_w = $signed({1'b0, req.step});
        prev_w = {{3{prev_reg[VW-1]}}, prev_reg};
        if (gap_w > step_w) begin
            slewed = VW'(prev_w + step_w);
        end else if (gap_w < -step_w) begin
            slewed = VW'(prev_w - step_w);
        end else begin
            slewed = target;
        end

        take      = 1'b0;
        vx_sel    = vx_ext;
        vy_sel    = vy_ext;
        prev_next = prev_reg;
        push_ext  = '0;
        case (req.state)
            oavs_pkg::ST_FRONT: begin
                take     = 1'b1;
                push_ext = -$signed({{(VW+1-oavs_pkg::PUSH_W){1'b0}}, push_f});
                if (vx_ext > 0) begin
                    vx_sel = '0;
                end
                if (push_ext < vx_sel) begin
                    vx_sel = push_ext;
                end
            end
            oavs_pkg::ST_REAR: begin
                take     = 1'b1;
                push_ext = $signed({{(VW+1-oavs_pkg::PUSH_W){1'b0}}, push_b});
                if (vx_ext < 0) begin
                    vx_sel = '0;
                end
                if (push_ext > vx_sel) begin
                    vx_sel = push_ext;
                end
            end
            oavs_pkg::ST_SIDE: begin
                take      = 1'b1;
                vy_sel    = {slewed[VW-1], slewed};
                prev_next = slewed;
            end
            default: begin
                if (req.load_prev) begin
                    prev_next = req.vy_in;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (advance) begin
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            take_reg <= take;
            vx_reg   <= take ? oavs_pkg::clamp_cmd(vx_sel) : '0;
            vy_reg   <= take ? oavs_pkg::clamp_cmd(vy_sel) : '0;
            mode_reg <= oavs_pkg::mode_code(req.state);
        end
    end

    assign take_over = take_reg;
    assign vx_out    = vx_reg;
    assign vy_out    = vy_reg;
    assign mode      = mode_reg;

endmodule

FILE: rtl/oavs_checker.sv
//------------------------------------------------------------------------------
// Obstacle avoidance velocity supervisor: port checker
// Watches the result channel of the supervisor and is bound to its top level.
//------------------------------------------------------------------------------
`include "obstacle_avoid_velocity_supervisor_defines.svh"

module oavs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser
);

    logic [oavs_pkg::MODE_W-1:0]       mode_f;
    logic signed [oavs_pkg::CMD_W-1:0] vx_f;
    logic signed [oavs_pkg::CMD_W-1:0] vy_f;

    assign mode_f = m_tdata[22:20];
    assign vx_f   = m_tdata[9:0];
    assign vy_f   = m_tdata[19:10];

    `OAVS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
    `OAVS_ASSERT_SAME(a_pass_zero, aclk, aresetn, m_tvalid && !m_tuser, (m_tdata[19:0] == 20'd0) && (mode_f == oavs_pkg::MODE_NORMAL || mode_f == oavs_pkg::MODE_CLEARING), "pass-through beat carries a command or an avoid mode")
    `OAVS_ASSERT_SAME(a_take_mode, aclk, aresetn, m_tvalid && m_tuser, mode_f == oavs_pkg::MODE_SIDE || mode_f == oavs_pkg::MODE_FRONT || mode_f == oavs_pkg::MODE_REAR, "override beat outside an avoid mode")
    `OAVS_ASSERT_SAME(a_cmd_limit, aclk, aresetn, m_tvalid && m_tuser, (vx_f <= oavs_pkg::SPEED_LIMIT) && (vx_f >= -oavs_pkg::SPEED_LIMIT) && (vy_f <= oavs_pkg::SPEED_LIMIT) && (vy_f >= -oavs_pkg::SPEED_LIMIT), "command beyond the speed limit")

endmodule

bind obstacle_avoid_velocity_supervisor oavs_checker u_oavs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/obstacle_avoid_velocity_supervisor_tb.sv
//------------------------------------------------------------------------------
// Obstacle avoidance velocity supervisor: testbench
// Streams control ticks into the supervisor and checks every command beat
// against a cycle-free model of the filters, the freshness timers, the mode
// machine and the velocity shaping, over several register settings, with
// random gaps on the tick stream and random back-pressure on the result stream.
//------------------------------------------------------------------------------
module obstacle_avoid_velocity_supervisor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import oavs_pkg::*;

    typedef struct packed {
        logic signed [VEL_W-1:0] vy_in;
        logic signed [VEL_W-1:0] vx_in;
        logic                    deck_ready;
        logic [RAW_W-1:0]        back_raw;
        logic [RAW_W-1:0]        right_raw;
        logic [RAW_W-1:0]        left_raw;
        logic [RAW_W-1:0]        front_raw;
        logic [TIME_W-1:0]       now_ms;
    } tick_t;

    typedef struct packed {
        logic                    take_over;
        logic [MODE_W-1:0]       mode;
        logic signed [CMD_W-1:0] vy_out;
        logic signed [CMD_W-1:0] vx_out;
    } cmd_t;

    class supervisor_scoreboard;
        bit                cfg_enable;
        int                front_enter, front_clear, side_enter, side_clear;
        int                back_enter, back_clear;
        logic [HOLD_W-1:0] clear_hold;

        logic [MODE_W-1:0] mode_now;
        bit                side_right;
        logic [FILT_W-1:0] filt [NUM_SENSORS];
        logic [TIME_W-1:0] seen [NUM_SENSORS];
        bit                timing;
        logic [TIME_W-1:0] timer_start;
        int                lateral_prev;
        logic [TIME_W-1:0] last_tick;

        cmd_t              cmd_expected_q [$];
        int                errors;
        int                beats;

        function new();
            cfg_enable  = 1'b0;
            front_enter = 400;
            front_clear = 550;
            side_enter  = 300;
            side_clear  = 450;
            back_enter  = 300;
            back_clear  = 450;
            clear_hold  = 300;
            mode_now    = MODE_NORMAL;
            side_right  = 1'b0;
            foreach (filt[k]) begin
                filt[k] = FILT_RESET;
                seen[k] = '0;
            end
            timing       = 1'b0;
            timer_start  = '0;
            lateral_prev = 0;
            last_tick    = '0;
            errors       = 0;
            beats        = 0;
        endfunction

        function void apply_reg(logic [CFG_ADDR_W-1:0] idx, int val);
            case (idx)
                CFG_ENABLE:      cfg_enable  = val[0];
                CFG_FRONT_ENTER: front_enter = val & 'h7FF;
                CFG_FRONT_CLEAR: front_clear = val & 'h7FF;
                CFG_SIDE_ENTER:  side_enter  = val & 'h7FF;
                CFG_SIDE_CLEAR:  side_clear  = val & 'h7FF;
                CFG_BACK_ENTER:  back_enter  = val & 'h7FF;
                CFG_BACK_CLEAR:  back_clear  = val & 'h7FF;
                CFG_CLEAR_HOLD:  clear_hold  = val[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function int push_away(int err16);
            if (err16 <= 0) return 0;
            return (err16 / 16 < PUSH_MAX) ? err16 / 16 : PUSH_MAX;
        endfunction

        function cmd_t supervise_tick(tick_t t);
            cmd_t              c;
            logic [TIME_W-1:0] dt, age, held;
            logic [RAW_W-1:0]  raw [NUM_SENSORS];
            int                u, d, vxi, vyi, vx, vy, f, l, r, b, near, err, tgt, p;
            longint            slew;
            bit                fresh, ready, take;
            c     = '0;
            vx    = 0;
            vy    = 0;
            fresh = 1'b0;
            ready = 1'b0;
            take  = 1'b0;
            vxi   = $signed(t.vx_in);
            vyi   = $signed(t.vy_in);
            dt    = t.now_ms - last_tick;
            last_tick = t.now_ms;
            if (!cfg_enable) begin
                mode_now = MODE_NORMAL;
                return c;
            end
            raw[SENS_FRONT] = t.front_raw;
            raw[SENS_LEFT]  = t.left_raw;
            raw[SENS_RIGHT] = t.right_raw;
            raw[SENS_BACK]  = t.back_raw;
            for (int k = 0; k < NUM_SENSORS; k++) begin
                if (raw[k] != 0) begin
                    u = (raw[k] > RANGE_MAX_MM) ? RANGE_MAX_MM * 16 : int'(raw[k]) * 16;
                    d = u - int'(filt[k]);
                    filt[k] = FILT_W'(int'(filt[k]) + (d >>> 2));
                    seen[k] = t.now_ms;
                end
                age = t.now_ms - seen[k];
                if (age <= STALE_MS) fresh = 1'b1;
            end
            if (!t.deck_ready || !fresh) begin
                mode_now = MODE_NORMAL;
                return c;
            end
            f = filt[SENS_FRONT];
            l = filt[SENS_LEFT];
            r = filt[SENS_RIGHT];
            b = filt[SENS_BACK];

            if (mode_now == MODE_NORMAL) begin
                if (f < front_enter * 16) begin
                    mode_now = MODE_FRONT;
                    timing   = 1'b0;
                end else if (b < back_enter * 16) begin
                    mode_now = MODE_REAR;
                    timing   = 1'b0;
                end else if (r < side_enter * 16) begin
                    mode_now   = MODE_SIDE;
                    side_right = 1'b1;
                    timing     = 1'b0;
                end else if (l < side_enter * 16) begin
                    mode_now   = MODE_SIDE;
                    side_right = 1'b0;
                    timing     = 1'b0;
                end
            end
            if (mode_now == MODE_SIDE && f < front_enter * 16) begin
                mode_now = MODE_FRONT;
                timing   = 1'b0;
            end
            near = side_right ? r : l;

            case (mode_now)
                MODE_FRONT: ready = f > front_clear * 16;
                MODE_REAR:  ready = b > back_clear * 16;
                MODE_SIDE:  ready = near > side_clear * 16 && f > front_enter * 16 &&
                                    b > back_enter * 16;
                default:    ready = 1'b0;
            endcase

            if (mode_now == MODE_FRONT || mode_now == MODE_REAR || mode_now == MODE_SIDE) begin
                if (ready) begin
                    if (!timing) begin
                        timing      = 1'b1;
                        timer_start = t.now_ms;
                    end
                    held = t.now_ms - timer_start;
                    if (held >= clear_hold) begin
                        mode_now = MODE_CLEARING;
                        timing   = 1'b0;
                    end
                end else begin
                    timing = 1'b0;
                end
            end else if (mode_now == MODE_CLEARING) begin
                mode_now     = MODE_NORMAL;
                lateral_prev = vyi;
            end

            case (mode_now)
                MODE_FRONT: begin
                    p    = -push_away(front_clear * 16 - f);
                    vx   = (vxi < 0) ? vxi : 0;
                    vx   = (vx < p) ? vx : p;
                    vy   = vyi;
                    take = 1'b1;
                end
                MODE_REAR: begin
                    p    = push_away(back_clear * 16 - b);
                    vx   = (vxi > 0) ? vxi : 0;
                    vx   = (vx > p) ? vx : p;
                    vy   = vyi;
                    take = 1'b1;
                end
                MODE_SIDE: begin
                    err = side_clear * 16 - near;
                    if (err > 0) begin
                        p   = push_away(err);
                        tgt = side_right ? p : -p;
                    end else begin
                        tgt = vyi;
                    end
                    slew = longint'(dt) * 2;
                    if (slew > SLEW_CAP) slew = SLEW_CAP;
                    if (tgt - lateral_prev > slew) begin
                        vy = lateral_prev + int'(slew);
                    end else if (tgt - lateral_prev < -slew) begin
                        vy = lateral_prev - int'(slew);
                    end else begin
                        vy = tgt;
                    end
                    lateral_prev = vy;
                    vx   = vxi;
                    take = 1'b1;
                end
                default: ;
            endcase

            if (take) begin
                vx = (vx > SPEED_LIMIT) ? SPEED_LIMIT : ((vx < -SPEED_LIMIT) ? -SPEED_LIMIT : vx);
                vy = (vy > SPEED_LIMIT) ? SPEED_LIMIT : ((vy < -SPEED_LIMIT) ? -SPEED_LIMIT : vy);
                c.take_over = 1'b1;
                c.vx_out    = CMD_W'(vx);
                c.vy_out    = CMD_W'(vy);
            end
            c.mode = mode_now;
            return c;
        endfunction

        function void note_tick(tick_t t);
            cmd_expected_q.push_back(supervise_tick(t));
        endfunction

        function int pending();
            return cmd_expected_q.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("[%0t] result beat %0d: %s", $time, beats, msg);
        endtask

        task check_beat(logic take, logic [23:0] data);
            cmd_t e;
            beats++;
            if (cmd_expected_q.size() == 0) begin
                report_mismatch("result beat with no command expected");
                return;
            end
            e = cmd_expected_q.pop_front();
            if (take !== e.take_over)
                report_mismatch($sformatf("take_over expected %0d got %0d", e.take_over, take));
            if (data[9:0] !== e.vx_out)
                report_mismatch($sformatf("vx_out expected %0d got %0d",
                                          e.vx_out, $signed(data[9:0])));
            if (data[19:10] !== e.vy_out)
                report_mismatch($sformatf("vy_out expected %0d got %0d",
                                          e.vy_out, $signed(data[19:10])));
            if (data[22:20] !== e.mode)
                report_mismatch($sformatf("mode expected %0d got %0d", e.mode, data[22:20]));
        endtask

        task report_leftovers();
            while (cmd_expected_q.size() != 0) begin
                void'(cmd_expected_q.pop_front());
                report_mismatch("expected command never arrived");
            end
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [127:0]          s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tuser;

    supervisor_scoreboard sb = new();
    int                   tx_pct = 0;
    int                   rx_pct = 0;
    logic                 rx_hold = 1'b0;
    logic [TIME_W-1:0]    clock_ms = '0;
    event                 rx_squeeze;

    obstacle_avoid_velocity_supervisor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (rx_hold) begin
            m_tready = 1'b0;
        end else begin
            m_tready = (rx_pct == 0) || ($urandom_range(0, 99) >= rx_pct);
        end
    end

    always begin
        @(rx_squeeze);
        rx_hold = 1'b1;
        repeat (80) @(posedge aclk);
        rx_hold = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tuser, m_tdata);
    end

    task automatic send_fields(logic [TIME_W-1:0] now, int fr, int lf, int rt, int bk,
                               bit deck, int vx, int vy);
        tick_t t;
        t.now_ms     = now;
        t.front_raw  = fr[15:0];
        t.left_raw   = lf[15:0];
        t.right_raw  = rt[15:0];
        t.back_raw   = bk[15:0];
        t.deck_ready = deck;
        t.vx_in      = vx[12:0];
        t.vy_in      = vy[12:0];
        clock_ms     = now;
        @(negedge aclk);
        while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, t};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(t);
    endtask

    task automatic quiesce();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, int val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = CFG_DATA_W'(val);
        sb.apply_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic program_regs(bit en, int fe, int fc, int se, int sc, int be, int bc,
                                int hold);
        quiesce();
        repeat (4) @(posedge aclk);
        set_reg(CFG_ENABLE, en);
        set_reg(CFG_FRONT_ENTER, fe);
        set_reg(CFG_FRONT_CLEAR, fc);
        set_reg(CFG_SIDE_ENTER, se);
        set_reg(CFG_SIDE_CLEAR, sc);
        set_reg(CFG_BACK_ENTER, be);
        set_reg(CFG_BACK_CLEAR, bc);
        set_reg(CFG_CLEAR_HOLD, hold);
    endtask

    // Each run of ticks moves the four obstacles at steady random speeds,
    // bouncing them between contact and out of range, so that the avoid modes
    // are entered and released; dropouts, glitches and time jumps are mixed in.
    task automatic run_traffic(int n_items, bit squeeze, bit drain);
        int range_mm [NUM_SENSORS];
        int speed [NUM_SENSORS];
        int rd [NUM_SENSORS];
        int sent, len, roll, vx, vy;
        logic [TIME_W-1:0] now;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(10, 60);
            for (int k = 0; k < NUM_SENSORS; k++) begin
                range_mm[k] = $urandom_range(0, 2200);
                speed[k]    = int'($urandom_range(0, 160)) - 80;
            end
            for (int i = 0; i < len && sent < n_items; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 1) begin
                    now = $urandom;
                end else if (roll < 4) begin
                    now = clock_ms + $urandom_range(150, 5000);
                end else begin
                    now = clock_ms + $urandom_range(1, 20);
                end
                for (int k = 0; k < NUM_SENSORS; k++) begin
                    range_mm[k] += speed[k] + int'($urandom_range(0, 40)) - 20;
                    if (range_mm[k] < 20) begin
                        speed[k]    = (speed[k] < 0) ? -speed[k] : speed[k];
                        range_mm[k] = (range_mm[k] < 0) ? 0 : range_mm[k];
                    end else if (range_mm[k] > 2300) begin
                        speed[k] = (speed[k] > 0) ? -speed[k] : speed[k];
                    end
                    roll = $urandom_range(0, 99);
                    if (roll < 10) begin
                        rd[k] = 0;
                    end else if (roll < 13) begin
                        rd[k] = $urandom_range(0, 65535);
                    end else begin
                        rd[k] = range_mm[k];
                    end
                end
                if ($urandom_range(0, 99) < 70) begin
                    vx = int'($urandom_range(0, 6000)) - 3000;
                    vy = int'($urandom_range(0, 6000)) - 3000;
                end else begin
                    vx = int'($urandom_range(0, 800)) - 400;
                    vy = int'($urandom_range(0, 800)) - 400;
                end
                send_fields(now, rd[SENS_FRONT], rd[SENS_LEFT], rd[SENS_RIGHT],
                            rd[SENS_BACK], $urandom_range(0, 99) >= 3, vx, vy);
                sent++;
                if (sent == n_items / 2) begin
                    if (squeeze) -> rx_squeeze;
                    if (drain) quiesce();
                end
            end
        end
    endtask

    initial begin
        int fe, se, be;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_fields(7, 65535, 65535, 65535, 65535, 1'b1, 3000, -3000);
        program_regs(1'b1, 1600, 1650, 1600, 1650, 1600, 1650, 20);
        send_fields(4000, 0, 0, 0, 0, 1'b1, -3000, 3000);
        send_fields(4010, 1, 65535, 2000, 2000, 1'b0, 3000, 3000);
        send_fields(4020, 0, 0, 0, 0, 1'b1, 3000, 3000);
        send_fields(4030, 2000, 2000, 2000, 2000, 1'b1, -50, -7);
        send_fields(4040, 2000, 2000, 2000, 2000, 1'b1, 100, 25);
        send_fields(4050, 2000, 2000, 2000, 2000, 1'b1, 0, 0);
        send_fields(4060, 2000, 2000, 2000, 2000, 1'b1, 0, 1234);
        send_fields(4070, 2000, 2000, 2000, 1, 1'b1, -3000, 0);
        send_fields(4080, 2000, 2000, 2000, 2000, 1'b1, 500, -20);
        send_fields(4090, 2000, 2000, 2000, 2000, 1'b1, 500, -20);
        send_fields(4100, 2000, 2000, 2000, 2000, 1'b1, 500, -20);
        send_fields(4110, 2000, 2000, 2000, 2000, 1'b1, 0, 1234);
        send_fields(40110, 0, 0, 1, 0, 1'b1, 77, 0);
        send_fields(40111, 0, 0, 1, 0, 1'b1, -77, 0);
        send_fields(40121, 0, 1, 0, 0, 1'b1, 10, 10);
        send_fields(40131, 1, 0, 0, 0, 1'b1, 3000, -3000);
        send_fields(32'hFFFF_FFF6, 2000, 2000, 2000, 2000, 1'b1, 0, 0);
        send_fields(4, 2000, 2000, 2000, 2000, 1'b1, 0, 0);
        send_fields(24, 2000, 2000, 2000, 2000, 1'b1, 0, 0);
        send_fields(34, 2000, 2000, 2000, 2000, 1'b1, 0, 0);
        send_fields(44, 2000, 1, 2000, 2000, 1'b1, 0, 2500);
        send_fields(54, 2000, 2000, 2000, 2000, 1'b1, 0, 2500);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: program_regs(1'b1, 400, 550, 300, 450, 300, 450, 300);
                1: program_regs(1'b1, 0, 0, 0, 0, 0, 0, 0);
                2: program_regs(1'b1, 2000, 2000, 2000, 2000, 2000, 2000, 65535);
                default: begin
                    fe = $urandom_range(100, 1200);
                    se = $urandom_range(100, 1200);
                    be = $urandom_range(100, 1200);
                    program_regs(phase != 3, fe, fe + $urandom_range(0, 400),
                                 se, se + $urandom_range(0, 400),
                                 be, be + $urandom_range(0, 400),
                                 $urandom_range(0, 400));
                end
            endcase
            if (phase < 3) begin
                tx_pct = 21;
                rx_pct = 50;
            end else if (phase < 6) begin
                tx_pct = 50;
                rx_pct = 21;
            end else begin
                tx_pct = 0;
                rx_pct = 0;
            end
            run_traffic(140, phase == 4 || phase == 7, phase == 5);
        end

        quiesce();
        repeat (10) @(posedge aclk);
        sb.report_leftovers();
        if (sb.errors == 0) begin
            $display("obstacle_avoid_velocity_supervisor verification clean");
        end else begin
            $display("obstacle_avoid_velocity_supervisor verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("obstacle_avoid_velocity_supervisor verification failed");
        $finish;
    end

endmodule
